// ===== rtl/core/slgs_pkg.sv =====
// Shared types and constants of the semi-Lagrangian grid sampler.
package slgs_pkg;

	localparam int VAL_W      = 32;
	localparam int VEL_W      = 16;
	localparam int TS_W       = 24;
	localparam int SIZE_REG_W = 9;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int COORD_IN_W = 8;
	localparam int FRAC_W     = 8;
	localparam int DISP_SHIFT = 16;
	localparam int PROD_W     = VEL_W + TS_W;
	localparam int DISP_W     = PROD_W - DISP_SHIFT;
	localparam int POS_W      = DISP_W + 2;
	localparam int INT_W      = POS_W - FRAC_W;
	localparam int WGT_W      = 2 * FRAC_W + 1;
	localparam int MAC_W      = VAL_W + WGT_W + 1;
	localparam int ACC_W      = MAC_W + 2;
	localparam int ACC_SHIFT  = 2 * FRAC_W;

	localparam logic [SIZE_REG_W-1:0] GRID_RESET = 9'd256;
	localparam logic [FRAC_W:0]       WGT_ONE    = 9'd256;

	typedef enum logic [0:0] {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_TIME_SCALE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_CORNER,
		ST_READ,
		ST_WAIT,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic mul_y;
		logic corner_x;
		logic corner_y;
	} bt_ctrl_t;

	typedef struct packed {
		logic       clear;
		logic       issue;
		logic       last;
		logic [1:0] corner;
	} bl_ctrl_t;

endpackage

// ===== rtl/core/slgs_field_mem.sv =====
// Single-port field memory with registered read data.
module slgs_field_mem import slgs_pkg::*; #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [VAL_W-1:0] wdata,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/slgs_backtrace.sv =====
// Backtrace datapath: shared velocity multiplier, corner split and edge clamp.
module slgs_backtrace import slgs_pkg::*; #(
	parameter int MAX_DIM = 256
) (
	input  logic                                  clk,
	input  bt_ctrl_t                              ctrl,
	input  logic [COORD_IN_W-1:0]                 cell_x,
	input  logic [COORD_IN_W-1:0]                 cell_y,
	input  logic signed [VEL_W-1:0]               vel_x,
	input  logic signed [VEL_W-1:0]               vel_y,
	input  logic signed [TS_W-1:0]                time_scale,
	input  logic [$clog2(MAX_DIM+1)-1:0]          size_w,
	input  logic [$clog2(MAX_DIM+1)-1:0]          size_h,
	output logic [$clog2(MAX_DIM)-1:0]            x0,
	output logic [$clog2(MAX_DIM)-1:0]            x1,
	output logic [$clog2(MAX_DIM)-1:0]            y0,
	output logic [$clog2(MAX_DIM)-1:0]            y1,
	output logic [FRAC_W-1:0]                     fx,
	output logic [FRAC_W-1:0]                     fy
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int SW = $clog2(MAX_DIM + 1);

	logic [COORD_IN_W-1:0]   cx_q, cy_q;
	logic signed [VEL_W-1:0] vx_q, vy_q;
	logic signed [VEL_W-1:0] mul_a;
	logic signed [PROD_W-1:0] prod;
	logic [DISP_W-1:0]       disp_q;
	logic [COORD_IN_W-1:0]   cc;
	logic [SW-1:0]           lim;
	logic [POS_W-1:0]        pos;
	logic signed [INT_W:0]   ipart;
	logic signed [INT_W:0]   ipart_p1;
	logic [CW-1:0]           lo, hi;
	logic [CW-1:0]           x0_q, x1_q, y0_q, y1_q;
	logic [FRAC_W-1:0]       fx_q, fy_q;

	function automatic logic [CW-1:0] clamp(input logic signed [INT_W:0] c,
		input logic [SW-1:0] l);
		logic signed [INT_W:0] ls;
		ls = $signed({{(INT_W + 1 - SW){1'b0}}, l});
		if (c < 0) begin
			return '0;
		end else if (c > ls) begin
			return CW'(l);
		end
		return CW'(c);
	endfunction

	assign mul_a = ctrl.mul_y ? vy_q : vx_q;
	assign prod  = mul_a * time_scale;

	// traced point in Q.8: cell * 256 - displacement
	assign cc    = ctrl.corner_y ? cy_q : cx_q;
	assign lim   = (ctrl.corner_y ? size_h : size_w) - SW'(1);
	assign pos   = {{(POS_W - COORD_IN_W - FRAC_W){1'b0}}, cc, {FRAC_W{1'b0}}}
		- {{(POS_W - DISP_W){disp_q[DISP_W-1]}}, disp_q};
	assign ipart    = $signed({pos[POS_W-1], pos[POS_W-1:FRAC_W]});
	assign ipart_p1 = ipart + (INT_W + 1)'(1);
	assign lo       = clamp(ipart, lim);
	assign hi       = clamp(ipart_p1, lim);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cx_q <= cell_x;
			cy_q <= cell_y;
			vx_q <= vel_x;
			vy_q <= vel_y;
		end
		if (ctrl.mul_en) begin
			disp_q <= prod[PROD_W-1:DISP_SHIFT];
		end
		if (ctrl.corner_x) begin
			x0_q <= lo;
			x1_q <= hi;
			fx_q <= pos[FRAC_W-1:0];
		end
		if (ctrl.corner_y) begin
			y0_q <= lo;
			y1_q <= hi;
			fy_q <= pos[FRAC_W-1:0];
		end
	end

	assign x0 = x0_q;
	assign x1 = x1_q;
	assign y0 = y0_q;
	assign y1 = y1_q;
	assign fx = fx_q;
	assign fy = fy_q;

endmodule

// ===== rtl/core/slgs_blend.sv =====
// Bilinear blend: per-corner weight, weight times value, accumulate.
module slgs_blend import slgs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bl_ctrl_t         ctrl,
	input  logic [FRAC_W-1:0] fx,
	input  logic [FRAC_W-1:0] fy,
	input  logic [VAL_W-1:0] rd_data,
	output logic             done,
	output logic [VAL_W-1:0] result
);

	logic [FRAC_W:0]          wx, wy;
	logic [2*FRAC_W+1:0]      wgt_full;
	logic [WGT_W-1:0]         weight_s1;
	logic                     v_s1, v_s2, last_s1, last_s2;
	logic signed [MAC_W-1:0]  prod_s2;
	logic [ACC_W-1:0]         acc_q;
	logic                     done_q;

	assign wx       = ctrl.corner[0] ? {1'b0, fx} : WGT_ONE - {1'b0, fx};
	assign wy       = ctrl.corner[1] ? {1'b0, fy} : WGT_ONE - {1'b0, fy};
	assign wgt_full = wx * wy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= ctrl.issue;
			v_s2    <= v_s1;
			last_s1 <= ctrl.issue & ctrl.last;
			last_s2 <= last_s1;
			done_q  <= v_s2 & last_s2;
		end
	end

	// weight lines up with the registered memory read of the same corner
	always_ff @(posedge clk) begin
		weight_s1 <= wgt_full[WGT_W-1:0];
		prod_s2   <= $signed(rd_data) * $signed({1'b0, weight_s1});
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W - MAC_W){prod_s2[MAC_W-1]}}, prod_s2};
		end
	end

	assign done   = done_q;
	assign result = acc_q[ACC_SHIFT+VAL_W-1:ACC_SHIFT];

endmodule

// ===== rtl/core/semi_lagrangian_grid_sampler_top.sv =====
// Top level of the semi-Lagrangian grid sampler: control, config, field memory.
//
// The block keeps a MAX_DIM x MAX_DIM field of signed Q16.16 values in a
// single-port memory, addressed y * MAX_DIM + x; memory contents are undefined
// until written, and no cell may be sampled before it was written. A write
// beat stores cell_value and the next beat can follow at once. A sample
// beat is taken in steps: the x and y multiplies on one shared 16x24
// velocity multiplier, the corner split and clamp (x with the y multiply),
// the four neighbour reads through the single memory port, and the drain
// of the weight multiply and accumulate into the output register. The result
// waits in the output register while new beats are taken; a further sample
// stalls at its end only if that register is still full. Grid sizes saturate
// to 1..MAX_DIM. Configuration is written through cfg_we / cfg_index / cfg_data
// while the block is idle; the user must see to it, the block does not check.
module semi_lagrangian_grid_sampler_top import slgs_pkg::*; #(
	parameter int MAX_DIM = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic [COORD_IN_W-1:0]  cell_x,
	input  logic [COORD_IN_W-1:0]  cell_y,
	input  logic signed [VAL_W-1:0] cell_value,
	input  logic signed [VEL_W-1:0] vel_x,
	input  logic signed [VEL_W-1:0] vel_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [VAL_W-1:0] sample_value
);

	localparam int CW    = $clog2(MAX_DIM);
	localparam int SW    = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	state_t                 state_q, state_d;
	logic [SIZE_REG_W-1:0]  grid_width_q, grid_height_q;
	logic signed [TS_W-1:0] time_scale_q;
	logic [SW-1:0]          size_w, size_h;
	logic [1:0]             rd_cnt_q;
	logic                   accept, out_free, out_load;
	logic                   out_valid_q;
	logic [VAL_W-1:0]       sample_value_q;
	bt_ctrl_t               bt_ctrl;
	bl_ctrl_t               bl_ctrl;
	logic [CW-1:0]          x0, x1, y0, y1;
	logic [FRAC_W-1:0]      fx, fy;
	logic                   mem_we;
	logic [AW-1:0]          mem_addr;
	logic [VAL_W-1:0]       mem_rdata;
	logic                   blend_done;
	logic [VAL_W-1:0]       blend_result;
	logic [CW-1:0]          rd_x, rd_y;

	function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] x,
		input logic [AW-1:0] y);
		return AW'(y * AW'(MAX_DIM) + x);
	endfunction

	function automatic logic [SW-1:0] eff_size(input logic [SIZE_REG_W-1:0] s);
		if (s == '0) begin
			return SW'(1);
		end else if (s > MAX_DIM) begin
			return SW'(MAX_DIM);
		end
		return SW'(s);
	endfunction

	assign size_w = eff_size(grid_width_q);
	assign size_h = eff_size(grid_height_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_RESET;
			grid_height_q <= GRID_RESET;
			time_scale_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH: begin
					grid_width_q <= cfg_data[SIZE_REG_W-1:0];
				end
				CFG_GRID_HEIGHT: begin
					grid_height_q <= cfg_data[SIZE_REG_W-1:0];
				end
				CFG_TIME_SCALE: begin
					time_scale_q <= $signed(cfg_data[TS_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && op_t'(operation) == OP_SAMPLE) begin
					state_d = ST_MUL_X;
				end
			end
			ST_MUL_X: begin
				state_d = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				state_d = ST_CORNER;
			end
			ST_CORNER: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				if (rd_cnt_q == 2'd3) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (blend_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready         = 1'b0;
		out_load         = 1'b0;
		bt_ctrl          = '0;
		bl_ctrl          = '0;
		bt_ctrl.load     = accept;
		bl_ctrl.clear    = accept;
		bl_ctrl.corner   = rd_cnt_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MUL_X: begin
				bt_ctrl.mul_en = 1'b1;
			end
			ST_MUL_Y: begin
				bt_ctrl.mul_en   = 1'b1;
				bt_ctrl.mul_y    = 1'b1;
				bt_ctrl.corner_x = 1'b1;
			end
			ST_CORNER: begin
				bt_ctrl.corner_y = 1'b1;
			end
			ST_READ: begin
				bl_ctrl.issue = 1'b1;
				bl_ctrl.last  = (rd_cnt_q == 2'd3);
			end
			ST_PUSH: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 2'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_value_q <= blend_result;
		end
	end

	// memory port: writes only while idle, neighbour reads only in ST_READ
	assign rd_x   = rd_cnt_q[0] ? x1 : x0;
	assign rd_y   = rd_cnt_q[1] ? y1 : y0;
	assign mem_we = accept && op_t'(operation) == OP_WRITE
		&& (cell_x < MAX_DIM) && (cell_y < MAX_DIM);
	assign mem_addr = (state_q == ST_READ) ? cell_addr(AW'(rd_x), AW'(rd_y))
		: cell_addr(AW'(cell_x), AW'(cell_y));

	slgs_field_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (cell_value),
		.rdata (mem_rdata)
	);

	slgs_backtrace #(
		.MAX_DIM (MAX_DIM)
	) u_backtrace (
		.clk        (clk),
		.ctrl       (bt_ctrl),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.time_scale (time_scale_q),
		.size_w     (size_w),
		.size_h     (size_h),
		.x0         (x0),
		.x1         (x1),
		.y0         (y0),
		.y1         (y1),
		.fx         (fx),
		.fy         (fy)
	);

	slgs_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (bl_ctrl),
		.fx      (fx),
		.fy      (fy),
		.rd_data (mem_rdata),
		.done    (blend_done),
		.result  (blend_result)
	);

	assign out_valid    = out_valid_q;
	assign sample_value = $signed(sample_value_q);

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the semi-Lagrangian grid sampler.
`timescale 1ns / 100ps

module tb_top;
	import slgs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 116;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT  = 3000;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [31:0] value;
		logic [15:0] vx;
		logic [15:0] vy;
	} field_beat_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [31:0] value;
		logic [15:0] vx;
		logic [15:0] vy;
		logic        known;
		logic [31:0] result;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] x0;
		logic [7:0] x1;
		logic [7:0] y0;
		logic [7:0] y1;
		logic [7:0] fx;
		logic [7:0] fy;
	} corner_t;

	typedef struct packed {
		logic [8:0]  width;
		logic [8:0]  height;
		logic [23:0] scale;
		logic        rand_scale;
		rx_mode_t    rx;
		int          burst_max;
		int          gap_max;
		logic        hold;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic [COORD_IN_W-1:0] cell_x;
	logic [COORD_IN_W-1:0] cell_y;
	logic signed [VAL_W-1:0] cell_value;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic out_valid;
	logic out_ready;
	logic signed [VAL_W-1:0] sample_value;

	semi_lagrangian_grid_sampler_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.cell_value   (cell_value),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_value (sample_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the field memory and the registers
	logic signed [31:0] fld_mem [0:65535];
	bit fld_written [0:65535];
	logic [8:0] cur_width;
	logic [8:0] cur_height;
	logic signed [23:0] cur_scale;

	logic [31:0] sample_queue [$];
	int error_count;
	int stall_cycles;
	int beats_sent;
	int burst_left;
	int burst_max;
	int gap_max;
	rx_mode_t rx_mode;
	bit hold_request;

	// reset config throughout: time_scale 0, so each sample is the cell itself
	stim_row_t directed_rows [0:20] = '{
		'{OP_WRITE,  8'd0,   8'd0,   32'h7FFF_FFFF, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_WRITE,  8'd1,   8'd0,   32'h8000_0000, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_WRITE,  8'd0,   8'd1,   32'h0000_0000, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_WRITE,  8'd1,   8'd1,   32'h0000_0001, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_SAMPLE, 8'd0,   8'd0,   32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 1'b1, 32'h7FFF_FFFF},
		'{OP_WRITE,  8'd255, 8'd255, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 1'b0, 32'h0},
		'{OP_SAMPLE, 8'd255, 8'd255, 32'h0000_0000, 16'h8000, 16'h7FFF, 1'b1, 32'h8000_0000},
		'{OP_WRITE,  8'd255, 8'd0,   32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_WRITE,  8'd255, 8'd1,   32'h0000_FFFF, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_SAMPLE, 8'd255, 8'd0,   32'h0000_0000, 16'hFFFF, 16'h0001, 1'b1, 32'hFFFF_FFFF},
		'{OP_WRITE,  8'd0,   8'd255, 32'h7FFF_0000, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_WRITE,  8'd1,   8'd255, 32'h0001_0000, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_SAMPLE, 8'd0,   8'd255, 32'h0000_0000, 16'h0000, 16'h0000, 1'b1, 32'h7FFF_0000},
		'{OP_WRITE,  8'd255, 8'd255, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_SAMPLE, 8'd255, 8'd255, 32'h0000_0000, 16'h0000, 16'h0000, 1'b1, 32'hFFFF_FFFF},
		'{OP_SAMPLE, 8'd0,   8'd0,   32'h1234_5678, 16'h0100, 16'hFF00, 1'b0, 32'h0},
		'{OP_WRITE,  8'd128, 8'd64,  32'h5555_5555, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_WRITE,  8'd129, 8'd64,  32'hAAAA_AAAA, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_WRITE,  8'd128, 8'd65,  32'h0000_0000, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_WRITE,  8'd129, 8'd65,  32'h0000_0001, 16'h0000, 16'h0000, 1'b0, 32'h0},
		'{OP_SAMPLE, 8'd128, 8'd64,  32'h0000_0000, 16'hAAAA, 16'h5555, 1'b0, 32'h0}
	};

	// grid sizes include zero and oversize values that saturate
	phase_t phase_plan [0:NUM_PHASES-1] = '{
		'{9'd256, 9'd256, 24'h010000, 1'b0, RX_ALWAYS,   1000, 0,  1'b0},
		'{9'd2,   9'd2,   24'h7FFFFF, 1'b0, RX_RANDOM,   8,    4,  1'b0},
		'{9'd0,   9'd1,   24'h800000, 1'b0, RX_PERIODIC, 4,    8,  1'b0},
		'{9'd511, 9'd300, 24'h00C000, 1'b0, RX_RANDOM,   30,   2,  1'b1},
		'{9'd4,   9'd5,   24'hFE8000, 1'b0, RX_PERIODIC, 6,    6,  1'b0},
		'{9'd256, 9'd2,   24'h000100, 1'b0, RX_RANDOM,   12,   3,  1'b0},
		'{9'd17,  9'd256, 24'h000000, 1'b1, RX_PERIODIC, 20,   5,  1'b0},
		'{9'd256, 9'd256, 24'h000000, 1'b1, RX_RANDOM,   5,    10, 1'b0}
	};

	function automatic int eff_size(input logic [8:0] s);
		if (s == 9'd0)
			return 1;
		if (s > 9'd256)
			return 256;
		return int'(s);
	endfunction

	function automatic logic [7:0] clamp_idx(input longint v, input longint n);
		longint c;
		c = v;
		if (c < 0)
			c = 0;
		else if (c > n - 1)
			c = n - 1;
		return c[7:0];
	endfunction

	function automatic corner_t trace_back(input logic [7:0] cx, input logic [7:0] cy,
			input logic signed [15:0] vx, input logic signed [15:0] vy);
		longint px;
		longint py;
		longint ix;
		longint iy;
		longint w;
		longint h;
		corner_t c;
		w = eff_size(cur_width);
		h = eff_size(cur_height);
		// Q.24 displacement floored to Q.8, then split into corner and fraction
		px = longint'(cx) * 256 - ((longint'(vx) * longint'(cur_scale)) >>> 16);
		py = longint'(cy) * 256 - ((longint'(vy) * longint'(cur_scale)) >>> 16);
		ix = px >>> 8;
		iy = py >>> 8;
		c.fx = px[7:0];
		c.fy = py[7:0];
		c.x0 = clamp_idx(ix, w);
		c.x1 = clamp_idx(ix + 1, w);
		c.y0 = clamp_idx(iy, h);
		c.y1 = clamp_idx(iy + 1, h);
		return c;
	endfunction

	function automatic longint cell_val(input logic [7:0] x, input logic [7:0] y);
		return longint'(fld_mem[{y, x}]);
	endfunction

	function automatic logic [31:0] predict_sample(input field_beat_t b);
		corner_t c;
		longint wx0;
		longint wx1;
		longint wy0;
		longint wy1;
		longint acc;
		c = trace_back(b.x, b.y, b.vx, b.vy);
		wx1 = c.fx;
		wy1 = c.fy;
		wx0 = 256 - wx1;
		wy0 = 256 - wy1;
		acc = cell_val(c.x0, c.y0) * wx0 * wy0 + cell_val(c.x1, c.y0) * wx1 * wy0
			+ cell_val(c.x1, c.y1) * wx1 * wy1 + cell_val(c.x0, c.y1) * wx0 * wy1;
		return 32'(acc >>> 16);
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_vel();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 1023) - 512);
	endfunction

	task automatic send_beat(input field_beat_t b, input bit known, input logic [31:0] known_val);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			if (gap_max != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
			end
		end
		in_valid   <= 1'b1;
		operation  <= b.op;
		cell_x     <= b.x;
		cell_y     <= b.y;
		cell_value <= b.value;
		vel_x      <= b.vx;
		vel_y      <= b.vy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		beats_sent++;
		if (b.op == OP_WRITE) begin
			fld_mem[{b.y, b.x}] = b.value;
			fld_written[{b.y, b.x}] = 1'b1;
		end else begin
			sample_queue.insert(sample_queue.size(), known ? known_val : predict_sample(b));
		end
		@(negedge clk);
	endtask

	// a sample may only touch cells already written
	task automatic fill_cell(input logic [7:0] x, input logic [7:0] y);
		field_beat_t b;
		if (!fld_written[{y, x}]) begin
			b.op    = OP_WRITE;
			b.x     = x;
			b.y     = y;
			b.value = rand_value();
			b.vx    = 16'($urandom);
			b.vy    = 16'($urandom);
			send_beat(b, 1'b0, 32'h0);
		end
	endtask

	task automatic random_item();
		field_beat_t b;
		corner_t c;
		int w;
		int h;
		w = eff_size(cur_width);
		h = eff_size(cur_height);
		b.value = rand_value();
		b.vx    = rand_vel();
		b.vy    = rand_vel();
		if ($urandom_range(0, 3) == 0) begin
			b.op = OP_WRITE;
			b.x  = 8'($urandom_range(0, 255));
			b.y  = 8'($urandom_range(0, 255));
			send_beat(b, 1'b0, 32'h0);
		end else begin
			b.op = OP_SAMPLE;
			b.x  = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, w - 1));
			b.y  = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, h - 1));
			c = trace_back(b.x, b.y, b.vx, b.vy);
			fill_cell(c.x0, c.y0);
			fill_cell(c.x1, c.y0);
			fill_cell(c.x0, c.y1);
			fill_cell(c.x1, c.y1);
			send_beat(b, 1'b0, 32'h0);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sample_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_config(input logic [8:0] w, input logic [8:0] h, input logic [23:0] s);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_data  <= {15'($urandom), w};
		@(negedge clk);
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_data  <= {15'($urandom), h};
		@(negedge clk);
		cfg_index <= CFG_TIME_SCALE;
		cfg_data  <= s;
		@(negedge clk);
		// no register here, must be ignored
		cfg_index <= CFG_UNUSED;
		cfg_data  <= 24'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_width  = w;
		cur_height = h;
		cur_scale  = s;
	endtask

	initial begin
		field_beat_t b;
		phase_t ph;
		logic [23:0] scale;
		int phase_end;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_GRID_WIDTH;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		operation  <= OP_WRITE;
		cell_x     <= '0;
		cell_y     <= '0;
		cell_value <= '0;
		vel_x      <= '0;
		vel_y      <= '0;
		cur_width    = GRID_RESET;
		cur_height   = GRID_RESET;
		cur_scale    = '0;
		error_count  = 0;
		beats_sent   = 0;
		burst_left   = 0;
		burst_max    = 4;
		gap_max      = 3;
		rx_mode      = RX_RANDOM;
		hold_request = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			b.op    = directed_rows[i].op;
			b.x     = directed_rows[i].x;
			b.y     = directed_rows[i].y;
			b.value = directed_rows[i].value;
			b.vx    = directed_rows[i].vx;
			b.vy    = directed_rows[i].vy;
			send_beat(b, directed_rows[i].known, directed_rows[i].result);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			ph = phase_plan[p];
			settle();
			scale = ph.rand_scale ? 24'($urandom) : ph.scale;
			load_config(ph.width, ph.height, scale);
			burst_max  = ph.burst_max;
			gap_max    = ph.gap_max;
			burst_left = 0;
			rx_mode    = ph.rx;
			if (ph.hold)
				hold_request = 1'b1;
			phase_end = beats_sent + ITEMS_PER_PHASE;
			while (beats_sent < phase_end)
				random_item();
		end

		settle();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// receiver: stall pattern per phase, plus one long hold-off to back up the block
	initial begin
		int rx_tick;
		rx_tick = 0;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			rx_tick++;
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:   out_ready <= 1'b1;
					RX_RANDOM:   out_ready <= ($urandom_range(0, 9) < 6);
					RX_PERIODIC: out_ready <= ((rx_tick % 11) < 6);
					default:     out_ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (sample_queue.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result beat: sample_value %h", sample_value);
				end else begin
					want = sample_queue.pop_front();
					if (sample_value !== want) begin
						error_count++;
						if (error_count <= 10)
							$display("mismatch: sample_value %h, expected %h", sample_value, want);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end else begin
			stall_cycles = 0;
		end
	end

endmodule

// ===== sim.f =====
rtl/core/slgs_pkg.sv
rtl/core/slgs_field_mem.sv
rtl/core/slgs_backtrace.sv
rtl/core/slgs_blend.sv
rtl/core/semi_lagrangian_grid_sampler_top.sv
verif/tb_top.sv
